// ----- rtl/core/wsd_pkg.sv -----
// Shared constants, status codes and controller/datapath types for the work-stealing deque array.
package wsd_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_WORKERS = 8;
    localparam int DEF_DEQUE_DEPTH = 64;

    // Fixed field widths
    localparam int CMD_W    = 1;
    localparam int WORKER_W = 3;
    localparam int TASK_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TAKE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OWN      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STOLEN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // Reset value of the active worker count
    localparam logic [CFG_W-1:0] WORKERS_RESET = 4'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                load_req;     // capture the accepted request
        logic                sel_victim;   // look at the victim deque instead of the worker's
        logic                push_empty;   // push into an empty deque at slot 0
        logic                push_append;  // push after the current tail
        logic                pop_tail;     // read the tail slot and retreat
        logic                pop_head;     // read the head slot and advance
        logic                load_out;     // load the result register
        logic                out_from_mem; // result handle comes from the store read
        logic [STATUS_W-1:0] out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_take;   // captured command is a take
        logic active;    // selected deque index is below the active count
        logic empty;     // selected deque is empty
        logic full;      // selected deque has no free slot
        logic out_free;  // result register can accept a new beat
    } t_dp_stat;

endpackage

// ----- rtl/core/wsd_req_if.sv -----
// Request channel: command, worker, victim and task handle with valid/ready.
interface wsd_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  command;
    logic [2:0]  worker;
    logic [2:0]  victim;
    logic [31:0] task_in;

    modport source (output valid, output command, output worker, output victim,
                    output task_in, input ready);
    modport sink   (input valid, input command, input worker, input victim,
                    input task_in, output ready);
endinterface

// ----- rtl/core/wsd_rsp_if.sv -----
// Result channel: status and returned task handle with valid/ready.
interface wsd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] task_out;

    modport source (output valid, output status, output task_out, input ready);
    modport sink   (input valid, input status, input task_out, output ready);
endinterface

// ----- rtl/core/wsd_cfg_if.sv -----
// Configuration write channel for the active worker count.
interface wsd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] workers_in_use;

    modport source (output valid, output workers_in_use, input ready);
    modport sink   (input valid, input workers_in_use, output ready);
endinterface

// ----- rtl/core/wsd_ctrl.sv -----
// Controller state machine sequencing lookup, store access and result load.
module wsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  wsd_pkg::t_dp_stat i_stat,
    output wsd_pkg::t_dp_cmd  o_cmd
);
    import wsd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OWN  = 2'd1;
    localparam logic [1:0] S_VIC  = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_pend_own, n_pend_own;
    t_dp_cmd    cmd;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd       = cmd;

    always_comb begin
        n_state    = r_state;
        n_pend_own = r_pend_own;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_OWN;
                end
            end
            S_OWN: begin
                if (i_stat.out_free) begin
                    if (!i_stat.is_take) begin
                        cmd.load_out = 1'b1;
                        n_state      = S_IDLE;
                        if (!i_stat.active || (!i_stat.empty && i_stat.full)) begin
                            cmd.out_status = ST_OVERFLOW;
                        end else if (i_stat.empty) begin
                            cmd.push_empty = 1'b1;
                            cmd.out_status = ST_PUSHED;
                        end else begin
                            cmd.push_append = 1'b1;
                            cmd.out_status  = ST_PUSHED;
                        end
                    end else if (!i_stat.active) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_NONE;
                        n_state        = S_IDLE;
                    end else if (!i_stat.empty) begin
                        cmd.pop_tail = 1'b1;
                        n_pend_own   = 1'b1;
                        n_state      = S_READ;
                    end else begin
                        n_state = S_VIC;
                    end
                end
            end
            S_VIC: begin
                cmd.sel_victim = 1'b1;
                if (i_stat.out_free) begin
                    if (!i_stat.active || i_stat.empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_NONE;
                        n_state        = S_IDLE;
                    end else begin
                        cmd.pop_head = 1'b1;
                        n_pend_own   = 1'b0;
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_from_mem = 1'b1;
                    cmd.out_status   = r_pend_own ? ST_OWN : ST_STOLEN;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_own <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_own <= n_pend_own;
        end
    end

endmodule

// ----- rtl/core/wsd_dp.sv -----
// Datapath: request capture, pointer table, task store and result register.
module wsd_dp #(
    parameter int NUM_WORKERS = wsd_pkg::DEF_NUM_WORKERS,
    parameter int DEQUE_DEPTH = wsd_pkg::DEF_DEQUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [wsd_pkg::CMD_W-1:0]       i_command,
    input  logic [wsd_pkg::WORKER_W-1:0]    i_worker,
    input  logic [wsd_pkg::WORKER_W-1:0]    i_victim,
    input  logic [wsd_pkg::TASK_W-1:0]      i_task_in,
    input  logic                            i_cfg_fire,
    input  logic [wsd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_rsp_ready,
    input  wsd_pkg::t_dp_cmd                i_cmd,
    output wsd_pkg::t_dp_stat               o_stat,
    output logic                            o_rsp_valid,
    output logic [wsd_pkg::STATUS_W-1:0]    o_status,
    output logic [wsd_pkg::TASK_W-1:0]      o_task_out
);
    import wsd_pkg::*;

    localparam int PW        = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
    localparam int WIDX      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int MEM_DEPTH = NUM_WORKERS * DEQUE_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEQUE_DEPTH - 1);

    // Captured request and configuration
    logic [CMD_W-1:0]    r_command;
    logic [WORKER_W-1:0] r_worker;
    logic [WORKER_W-1:0] r_victim;
    logic [TASK_W-1:0]   r_task;
    logic [CFG_W-1:0]    r_wiu;

    // Per-deque pointer table
    logic [PW-1:0] r_head  [NUM_WORKERS];
    logic [PW-1:0] r_tail  [NUM_WORKERS];
    logic          r_empty [NUM_WORKERS];

    // Task store and its registered read
    logic [TASK_W-1:0] mem [MEM_DEPTH];
    logic [TASK_W-1:0] r_rd_data;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TASK_W-1:0]   r_out_task;

    logic [WORKER_W-1:0] sel;
    logic [WIDX-1:0]     sel_idx;
    logic                sel_active;
    logic [PW-1:0]       ent_head, ent_tail, tail_next, tail_prev, head_next;
    logic                ent_empty;
    logic [PW-1:0]       slot;
    logic [AW-1:0]       addr;
    logic                mem_wr, mem_rd;

    assign sel        = i_cmd.sel_victim ? r_victim : r_worker;
    assign sel_idx    = WIDX'(sel);
    assign sel_active = ({29'd0, sel} < 32'(NUM_WORKERS)) && ({1'b0, sel} < r_wiu);

    always_comb begin
        if (sel_active) begin
            ent_head  = r_head[sel_idx];
            ent_tail  = r_tail[sel_idx];
            ent_empty = r_empty[sel_idx];
        end else begin
            ent_head  = '0;
            ent_tail  = '0;
            ent_empty = 1'b1;
        end
    end

    assign tail_next = (ent_tail == LAST_SLOT) ? '0 : ent_tail + PW'(1);
    assign tail_prev = (ent_tail == '0) ? LAST_SLOT : ent_tail - PW'(1);
    assign head_next = (ent_head == LAST_SLOT) ? '0 : ent_head + PW'(1);

    assign o_stat.is_take  = (r_command == CMD_TAKE);
    assign o_stat.active   = sel_active;
    assign o_stat.empty    = ent_empty;
    assign o_stat.full     = (tail_next == ent_head);
    assign o_stat.out_free = !r_out_valid || i_rsp_ready;

    // Slot within the selected deque for this access
    always_comb begin
        if (i_cmd.push_empty) begin
            slot = '0;
        end else if (i_cmd.push_append) begin
            slot = tail_next;
        end else if (i_cmd.pop_head) begin
            slot = ent_head;
        end else begin
            slot = ent_tail;
        end
    end

    assign addr   = AW'(sel_idx) * AW'(DEQUE_DEPTH) + AW'(slot);
    assign mem_wr = i_cmd.push_empty || i_cmd.push_append;
    assign mem_rd = i_cmd.pop_tail || i_cmd.pop_head;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem[addr] <= r_task;
        end
        if (mem_rd) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_command <= i_command;
            r_worker  <= i_worker;
            r_victim  <= i_victim;
            r_task    <= i_task_in;
        end
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_task   <= i_cmd.out_from_mem ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu       <= WORKERS_RESET;
            r_out_valid <= 1'b0;
            for (int w = 0; w < NUM_WORKERS; w++) begin
                r_head[w]  <= '0;
                r_tail[w]  <= '0;
                r_empty[w] <= 1'b1;
            end
        end else begin
            if (i_cfg_fire) begin
                r_wiu <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.push_empty) begin
                r_head[sel_idx]  <= '0;
                r_tail[sel_idx]  <= '0;
                r_empty[sel_idx] <= 1'b0;
            end
            if (i_cmd.push_append) begin
                r_tail[sel_idx] <= tail_next;
            end
            if (i_cmd.pop_tail) begin
                if (ent_head == ent_tail) begin
                    r_empty[sel_idx] <= 1'b1;
                end else begin
                    r_tail[sel_idx] <= tail_prev;
                end
            end
            if (i_cmd.pop_head) begin
                if (ent_head == ent_tail) begin
                    r_empty[sel_idx] <= 1'b1;
                end else begin
                    r_head[sel_idx] <= head_next;
                end
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_task_out  = r_out_task;

endmodule

// ----- rtl/core/work_stealing_deque_array.sv -----
// Top level of the work-stealing deque array: controller, datapath and channel wiring.
//
//  channel  | dir | beat content                          | handshake
//  ---------+-----+---------------------------------------+------------
//  i_req    | in  | command, worker, victim, task_in      | valid/ready
//  o_rsp    | out | status, task_out                      | valid/ready
//  i_cfg    | in  | workers_in_use                        | valid/ready
//
// Sequence: S_IDLE accepts a request beat; a push or a take by an inactive
// worker then ends in S_OWN, a take from the own tail goes on to S_READ, a
// take that finds no victim to steal from goes on to S_VIC, and a steal goes
// through S_VIC and S_READ. The single lookup port on the pointer table (worker
// first, then victim) and the registered read of the task store set these steps.
// Reset: synchronous, active low; all deques empty, workers_in_use = 1. The
// task store has no clearing pass: only slots holding live handles are read.
// Stalls: the result register holds its beat while o_rsp.ready is low; the
// next request is accepted as soon as the previous one has been handed to it.
module work_stealing_deque_array #(
    parameter int NUM_WORKERS = wsd_pkg::DEF_NUM_WORKERS,
    parameter int DEQUE_DEPTH = wsd_pkg::DEF_DEQUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_req_if.sink    i_req,
    wsd_rsp_if.source  o_rsp,
    wsd_cfg_if.sink    i_cfg
);
    import wsd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     req_ready;

    // Configuration is always taken; the register lives in the datapath.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    // Sequence each request: lookup, optional store access, result load.
    wsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Hold the pointers, the shared task store and the result register.
    wsd_dp #(
        .NUM_WORKERS (NUM_WORKERS),
        .DEQUE_DEPTH (DEQUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_command   (i_req.command),
        .i_worker    (i_req.worker),
        .i_victim    (i_req.victim),
        .i_task_in   (i_req.task_in),
        .i_cfg_fire  (i_cfg.valid),
        .i_cfg_data  (i_cfg.workers_in_use),
        .i_rsp_ready (o_rsp.ready),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_rsp_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_task_out  (o_rsp.task_out)
    );

    // One request in flight: after an accepted beat, drop ready.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // At most one pointer update per cycle.
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.push_empty, dp_cmd.push_append, dp_cmd.pop_tail, dp_cmd.pop_head}))
        else $error("more than one deque update in a cycle");

    // A handle is returned only with an own-take or steal status.
    a_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OWN && o_rsp.status != ST_STOLEN)
        |-> (o_rsp.task_out == '0))
        else $error("nonzero task handle with a status that carries none");

    // A store access only happens for an active deque.
    a_access_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.push_empty || dp_cmd.push_append || dp_cmd.pop_tail || dp_cmd.pop_head)
        |-> dp_stat.active)
        else $error("store access on an inactive deque");

endmodule
